// ----- design/esrc_pkg.sv -----
// Package for the space-run compressor: shared widths, byte codes and defaults.
package esrc_pkg;

  localparam int CHAR_W            = 8;
  localparam int CFG_W             = 4;
  // Compare width: holds a column count of up to sixteen.
  localparam int CMP_W             = 5;
  localparam int MAX_TAB_WIDTH_DEF = 8;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic [CFG_W-1:0]  TAB_WIDTH_RST = 4'd4;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

endpackage

// ----- design/esrc_ifs.sv -----
// Valid/ready channel interfaces for the input bytes and the emitted bytes.
interface esrc_in_if;
  logic                        valid;
  logic                        ready;
  logic [esrc_pkg::CHAR_W-1:0] in_char;
  logic                        flush;

  modport source (output valid, output in_char, output flush, input ready);
  modport sink   (input valid, input in_char, input flush, output ready);
endinterface

interface esrc_out_if;
  logic                        valid;
  logic                        ready;
  logic [esrc_pkg::CHAR_W-1:0] out_char;
  logic                        last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

// ----- design/esrc_front.sv -----
// Front end: accepts bytes, tracks column and pending spaces, issues emit commands.
module esrc_front #(
  parameter int MAX_TAB_WIDTH = esrc_pkg::MAX_TAB_WIDTH_DEF,
  parameter int CMD_W         = $clog2(MAX_TAB_WIDTH) + 1 + esrc_pkg::CHAR_W
) (
  input  logic                       clk,
  input  logic                       rst_n,
  esrc_in_if.sink                    in_ch,
  input  logic                       cfg_we,
  input  logic [esrc_pkg::CFG_W-1:0] cfg_wdata,
  output logic                       q_push,
  output logic [CMD_W-1:0]           q_data,
  input  logic                       q_full
);
  import esrc_pkg::*;

  localparam int PW = $clog2(MAX_TAB_WIDTH);

  logic [CFG_W-1:0]  tab_width_r;
  logic [PW-1:0]     pending_r, pending_nxt;
  logic [PW-1:0]     phase_r, phase_nxt;
  logic [CMP_W-1:0]  eff_w;
  logic [CMP_W-1:0]  phase_inc;
  logic [PW-1:0]     phase_adv;
  logic              at_stop;
  logic              accept;
  logic              cmd_req;
  logic [PW-1:0]     cmd_cnt;
  logic              cmd_has_char;
  logic [CHAR_W-1:0] cmd_char;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    if (tab_width_r == '0) begin
      eff_w = CMP_W'(1);
    end else if (CMP_W'(tab_width_r) > CMP_W'(MAX_TAB_WIDTH)) begin
      eff_w = CMP_W'(MAX_TAB_WIDTH);
    end else begin
      eff_w = CMP_W'(tab_width_r);
    end
  end

  assign phase_inc = CMP_W'(phase_r) + CMP_W'(1);
  assign at_stop   = phase_inc >= eff_w;
  assign phase_adv = at_stop ? '0 : phase_r + PW'(1);

  always_comb begin
    pending_nxt  = pending_r;
    phase_nxt    = phase_r;
    cmd_req      = 1'b0;
    cmd_cnt      = '0;
    cmd_has_char = 1'b0;
    cmd_char     = in_ch.in_char;
    if (in_ch.flush) begin
      cmd_req     = pending_r != '0;
      cmd_cnt     = pending_r;
      pending_nxt = '0;
      phase_nxt   = '0;
    end else begin
      case (in_ch.in_char)
        CH_SPACE: begin
          if (at_stop) begin
            cmd_req      = 1'b1;
            cmd_has_char = 1'b1;
            cmd_char     = (pending_r == '0) ? CH_SPACE : CH_TAB;
            pending_nxt  = '0;
            phase_nxt    = '0;
          end else begin
            pending_nxt = pending_r + PW'(1);
            phase_nxt   = phase_adv;
          end
        end
        CH_TAB: begin
          cmd_req      = 1'b1;
          cmd_has_char = 1'b1;
          pending_nxt  = '0;
          phase_nxt    = '0;
        end
        CH_NL: begin
          cmd_req      = 1'b1;
          cmd_cnt      = pending_r;
          cmd_has_char = 1'b1;
          pending_nxt  = '0;
          phase_nxt    = '0;
        end
        default: begin
          cmd_req      = 1'b1;
          cmd_cnt      = pending_r;
          cmd_has_char = 1'b1;
          pending_nxt  = '0;
          phase_nxt    = phase_adv;
        end
      endcase
    end
  end

  assign q_push = accept && cmd_req;
  assign q_data = {cmd_cnt, cmd_has_char, cmd_char};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tab_width_r <= TAB_WIDTH_RST;
      pending_r   <= '0;
      phase_r     <= '0;
    end else begin
      if (cfg_we) begin
        tab_width_r <= cfg_wdata;
      end
      if (accept) begin
        pending_r <= pending_nxt;
        phase_r   <= phase_nxt;
      end
    end
  end

`ifndef ASSERT_OFF
  // Every held space sits in a column of the current interval.
  a_pending_le_phase: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= phase_r)
    else $error("pending space count exceeds column phase");
`endif

endmodule

// ----- design/esrc_queue.sv -----
// Short command queue between the front end and the emitter.
module esrc_queue #(
  parameter int WIDTH = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  import esrc_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] entry_r [QUEUE_DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = count_r == CW'(QUEUE_DEPTH);
  assign not_empty = count_r != '0;
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("command pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("command popped from an empty queue");
`endif

endmodule

// ----- design/esrc_back.sv -----
// Emitter: expands each command into pending spaces and a closing byte.
module esrc_back #(
  parameter int MAX_TAB_WIDTH = esrc_pkg::MAX_TAB_WIDTH_DEF,
  parameter int CMD_W         = $clog2(MAX_TAB_WIDTH) + 1 + esrc_pkg::CHAR_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [CMD_W-1:0] q_data,
  output logic             q_pop,
  esrc_out_if.source       out_ch
);
  import esrc_pkg::*;

  localparam int PW = $clog2(MAX_TAB_WIDTH);

  logic              work_valid_r, work_valid_nxt;
  logic [PW-1:0]     rem_r, rem_nxt;
  logic              has_char_r, has_char_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic              adv;
  logic              final_item;
  logic [PW-1:0]     q_cnt;
  logic              q_has_char;
  logic [CHAR_W-1:0] q_char;

  assign {q_cnt, q_has_char, q_char} = q_data;

  assign adv        = !out_valid_r || out_ch.ready;
  assign final_item = (rem_r == '0) || (rem_r == PW'(1) && !has_char_r);
  assign q_pop      = q_valid && (!work_valid_r || (adv && final_item));

  always_comb begin
    work_valid_nxt = work_valid_r;
    rem_nxt        = rem_r;
    has_char_nxt   = has_char_r;
    char_nxt       = char_r;
    out_valid_nxt  = out_valid_r;
    out_char_nxt   = out_char_r;
    out_last_nxt   = out_last_r;
    if (adv) begin
      out_valid_nxt = work_valid_r;
      out_last_nxt  = final_item;
      if (rem_r != '0) begin
        out_char_nxt = CH_SPACE;
        rem_nxt      = rem_r - PW'(1);
      end else begin
        out_char_nxt = char_r;
      end
      if (work_valid_r && final_item) begin
        work_valid_nxt = 1'b0;
      end
    end
    if (q_pop) begin
      work_valid_nxt = 1'b1;
      rem_nxt        = q_cnt;
      has_char_nxt   = q_has_char;
      char_nxt       = q_char;
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    has_char_r <= has_char_nxt;
    char_r     <= char_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

`ifndef ASSERT_OFF
  // A live command always has something left to emit.
  a_no_empty_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (work_valid_r && rem_r == '0) |-> has_char_r)
    else $error("emitter holds a command with nothing to emit");
`endif

endmodule

// ----- design/entab_space_run_compressor.sv -----
// Top level of the space-run compressor: front end, command queue and emitter.
//
// Usage: text bytes enter on in_ch (valid/ready) as in_char with a flush flag;
// a request with flush set releases the trailing held spaces and its byte is
// ignored. Emitted bytes leave on out_ch (valid/ready) as out_char, with last
// marking the final byte caused by one input request. tab_width is written
// through cfg_we/cfg_wdata while the block is idle; zero acts as one and values
// above MAX_TAB_WIDTH saturate.
// The first byte caused by a request passes the queue entry, the emitter's
// work registers and the output register. Throughput: one request per cycle
// while each yields at most one byte and out_ch.ready is high. A request that
// releases n held spaces yields n spaces, then its byte (only the spaces for a
// flush), one byte per cycle while out_ch is ready; the front end keeps taking
// requests until the two-entry command queue fills, then holds in_ch.ready low.
// Reset (rst_n low at a clock edge) empties the queue, clears the column and
// held-space counts and sets tab_width to four. When the receiver stalls, the
// output register holds its byte, the emitter waits, and the queue absorbs up
// to two commands before the input side stalls too.
module entab_space_run_compressor #(
  parameter int MAX_TAB_WIDTH = esrc_pkg::MAX_TAB_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  esrc_in_if.sink                    in_ch,
  esrc_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [esrc_pkg::CFG_W-1:0] cfg_wdata
);
  import esrc_pkg::*;

  // A command carries the held-space count, a closing-byte flag and the byte.
  localparam int PW    = $clog2(MAX_TAB_WIDTH);
  localparam int CMD_W = PW + 1 + CHAR_W;

  logic             q_push;
  logic [CMD_W-1:0] q_push_data;
  logic             q_full;
  logic             q_pop;
  logic [CMD_W-1:0] q_pop_data;
  logic             q_not_empty;

  // The front end classifies each byte and decides what it releases.
  esrc_front #(
    .MAX_TAB_WIDTH (MAX_TAB_WIDTH),
    .CMD_W         (CMD_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_data    (q_push_data),
    .q_full    (q_full)
  );

  // The queue lets the front end keep accepting while the emitter is busy.
  esrc_queue #(
    .WIDTH (CMD_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  // The emitter expands commands into output bytes, one per cycle while out_ch is ready.
  esrc_back #(
    .MAX_TAB_WIDTH (MAX_TAB_WIDTH),
    .CMD_W         (CMD_W)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- verif/tb_entab_space_run_compressor.sv -----
// Self-checking testbench for the space-run compressor, with a built-in tab predictor.
module tb_entab_space_run_compressor;
  timeunit 1ns;
  timeprecision 1ps;

  import esrc_pkg::*;

  // The block is built with its default tab width ceiling, and the predictor
  // clamps to the same value.
  localparam int MAXW = MAX_TAB_WIDTH_DEF;
  // Cycles of the run after which we give up.
  localparam int LIMIT_CYCLES = 200000;
  // Cycles allowed after the queue of expected bytes empties before a
  // register write. A request that emits nothing may still be in the pipe.
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int IDLE_PCT = 17;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } emit_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  esrc_in_if  in_ch ();
  esrc_out_if out_ch ();

  entab_space_run_compressor #(
    .MAX_TAB_WIDTH(MAXW)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the tab width register, the count of held spaces and
  // the column within the current tab interval.
  logic [CFG_W-1:0] tab_w;
  int unsigned      held_spaces;
  int unsigned      col_phase;

  // Bytes the block is expected to emit, oldest first.
  emit_byte_t emit_q[$];

  // Handshake knobs. When a gap flag is clear, that side never idles.
  bit in_gaps_en;
  bit out_stall_en;

  int unsigned error_cnt;
  int unsigned cycle_cnt;

  // Free-running clock, 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog. A hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
               emit_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic void note_error(input string msg);
    error_cnt++;
    if (error_cnt <= MAX_REPORTS) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endfunction

  // Works out what one accepted request makes the block emit and queues it.
  // Spaces are held back until a tab stop turns them into a tab (or a lone
  // space), or until some other byte or a flush releases them as spaces.
  function automatic void model_request(input logic [CHAR_W-1:0] ch, input logic fl);
    emit_byte_t  outs[$];
    emit_byte_t  eb;
    int unsigned w;
    w = (tab_w == '0) ? 1 : ((int'(tab_w) > MAXW) ? MAXW : int'(tab_w));
    eb.last = 1'b0;
    if (fl) begin
      // Flush: trailing spaces go out as spaces and the line starts over.
      eb.ch = CH_SPACE;
      repeat (held_spaces) outs.push_back(eb);
      held_spaces = 0;
      col_phase = 0;
    end else if (ch == CH_SPACE) begin
      held_spaces++;
      // A phase left beyond a narrowed width also counts as a stop here.
      if (col_phase + 1 >= w) begin
        eb.ch = (held_spaces == 1) ? CH_SPACE : CH_TAB;
        outs.push_back(eb);
        held_spaces = 0;
        col_phase = 0;
      end else begin
        col_phase++;
      end
    end else if (ch == CH_TAB) begin
      // An input tab swallows whatever spaces were held before it.
      held_spaces = 0;
      eb.ch = CH_TAB;
      outs.push_back(eb);
      col_phase = 0;
    end else begin
      eb.ch = CH_SPACE;
      repeat (held_spaces) outs.push_back(eb);
      held_spaces = 0;
      eb.ch = ch;
      outs.push_back(eb);
      if (ch == CH_NL || col_phase + 1 >= w) begin
        col_phase = 0;
      end else begin
        col_phase++;
      end
    end
    if (outs.size() > 0) begin
      outs[outs.size()-1].last = 1'b1;
    end
    foreach (outs[i]) emit_q.push_back(outs[i]);
  endfunction

  // Result side: compare every accepted byte with the oldest expectation and
  // drive the receiver's ready with random stalls.
  always @(posedge clk) begin : check_emit
    emit_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (emit_q.size() == 0) begin
        note_error($sformatf("unexpected byte 0x%02h last=%0b", out_ch.out_char,
                             out_ch.last));
      end else begin
        want = emit_q.pop_front();
        if (out_ch.out_char !== want.ch || out_ch.last !== want.last) begin
          note_error($sformatf("byte mismatch: expected 0x%02h last=%0b, got 0x%02h last=%0b",
                               want.ch, want.last, out_ch.out_char, out_ch.last));
        end
      end
    end
    out_ch.ready <= out_stall_en ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
  end

  // Offers one request, with a random number of idle cycles first, and
  // returns at the edge where the block takes it. The prediction is made at
  // that same edge.
  task automatic send_request(input logic [CHAR_W-1:0] ch, input logic fl);
    while (in_gaps_en && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_char <= ch;
    in_ch.flush   <= fl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    model_request(ch, fl);
  endtask

  // Stops offering requests and waits until every expected byte has come,
  // then lets the given number of further cycles pass (at least one).
  task automatic wait_drained(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (emit_q.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Writes the tab width register while the block is idle. The held spaces
  // and the column phase carry over, so a write can land mid-line.
  task automatic set_tab_width(input logic [CFG_W-1:0] w);
    wait_drained(SETTLE_CYCLES);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    tab_w = w;
    cfg_we <= 1'b0;
  endtask

  // Picks one byte of random text. Spaces dominate so that runs of various
  // lengths reach tab stops; tabs, newlines, flushes and arbitrary bytes
  // break the runs.
  task automatic pick_text(output logic [CHAR_W-1:0] ch, output logic fl);
    int r;
    r = $urandom_range(0, 99);
    fl = 1'b0;
    if (r < 45) begin
      ch = CH_SPACE;
    end else if (r < 52) begin
      ch = CH_TAB;
    end else if (r < 59) begin
      ch = CH_NL;
    end else if (r < 64) begin
      // The byte of a flush request is ignored, so anything goes there.
      fl = 1'b1;
      ch = CHAR_W'($urandom_range(0, 255));
    end else if (r < 84) begin
      ch = CHAR_W'($urandom_range(8'h21, 8'h7E));
    end else begin
      ch = CHAR_W'($urandom_range(0, 255));
    end
  endtask

  // At the reset width of four: a run that reaches a stop becomes a tab, a
  // single space at a stop stays a space, the extreme byte values pass
  // through, an input tab drops held spaces, a newline releases them, and a
  // flush releases them or does nothing when none are held.
  task automatic test_default_width();
    send_request(8'h41, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_TAB, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_NL, 1'b0);
    send_request(CH_SPACE, 1'b0);
    send_request(CH_SPACE, 1'b1);
    send_request(8'hFF, 1'b1);
  endtask

  // Width zero acts as one, so every space is its own stop. Width fifteen
  // saturates to the ceiling: seven held spaces and a letter make the
  // longest burst one request can cause.
  task automatic test_width_clamp();
    set_tab_width(4'd0);
    send_request(CH_SPACE, 1'b0);
    set_tab_width(4'd15);
    repeat (MAXW - 1) send_request(CH_SPACE, 1'b0);
    send_request(8'h78, 1'b0);
  endtask

  // Narrow the width while spaces are held and the phase sits past the new
  // width: the next space must count as reaching a stop.
  task automatic test_midline_width_change();
    repeat (5) send_request(CH_SPACE, 1'b0);
    set_tab_width(4'd2);
    send_request(CH_SPACE, 1'b0);
  endtask

  // A block of random text at a given width. With pause_at >= 0 the sender
  // stops at that point until every expected byte has arrived.
  task automatic test_random_text(input logic [CFG_W-1:0] w, input int n, input int pause_at);
    logic [CHAR_W-1:0] ch;
    logic              fl;
    set_tab_width(w);
    for (int i = 0; i < n; i++) begin
      if (i == pause_at) begin
        wait_drained(1);
      end
      pick_text(ch, fl);
      send_request(ch, fl);
    end
  endtask

  initial begin
    // Every input has a known value before the first edge.
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.in_char = '0;
    in_ch.flush   = 1'b0;
    out_ch.ready  = 1'b0;
    in_gaps_en    = 1'b1;
    out_stall_en  = 1'b1;
    error_cnt     = 0;
    cycle_cnt     = 0;
    tab_w         = TAB_WIDTH_RST;
    held_spaces   = 0;
    col_phase     = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_default_width();
    test_width_clamp();
    test_midline_width_change();

    // Random text over several widths, the extremes among them. The fourth
    // block runs with no idling on either side.
    test_random_text(4'd15, 60, -1);
    test_random_text(4'd1, 60, 30);
    test_random_text(4'd0, 60, -1);
    in_gaps_en   = 1'b0;
    out_stall_en = 1'b0;
    test_random_text(4'd8, 70, -1);
    in_gaps_en   = 1'b1;
    out_stall_en = 1'b1;
    test_random_text(4'($urandom_range(3, 7)), 60, -1);
    test_random_text(4'd2, 60, -1);

    // Let the last bytes come out, then wait out the settle time to catch strays.
    wait_drained(SETTLE_CYCLES);

    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
